// ===== sv/ridft_pkg.sv =====
// Shared types and constants of the real inverse DFT block.
`timescale 1ns / 1ps

package ridft_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 16;
    localparam int BIN_W    = 6;
    localparam int COS_W    = 16;
    localparam int PROD_W   = 32;

    // Fixed-point constants used to build the cosine table at elaboration.
    localparam longint Q30_ONE = longint'(1) << 30;
    localparam longint PI_Q30  = 64'sd3373259426;

    typedef enum logic {
        ST_LOAD,
        ST_COMPUTE
    } t_state;

endpackage

// ===== sv/ridft_in_if.sv =====
// Input channel of the real inverse DFT: one frequency-domain sample per item.
`timescale 1ns / 1ps

interface ridft_in_if;
    import ridft_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== sv/ridft_out_if.sv =====
// Output channel of the real inverse DFT: one time-domain value per item.
`timescale 1ns / 1ps

interface ridft_out_if;
    import ridft_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [BIN_W-1:0]          bin_index;
    logic                      last;

    modport source (output valid, output value, output bin_index, output last, input ready);
    modport sink   (input valid, input value, input bin_index, input last, output ready);
endinterface

// ===== sv/ridft_cell.sv =====
// One cell of the sample ring: holds a sample and passes it on when enabled.
`timescale 1ns / 1ps

module ridft_cell (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [ridft_pkg::SAMPLE_W-1:0] i_d,
    output logic signed [ridft_pkg::SAMPLE_W-1:0] o_q
);
    import ridft_pkg::*;

    logic signed [SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== sv/ridft_rom.sv =====
// Cosine table of the real inverse DFT with a registered read port.
`timescale 1ns / 1ps

module ridft_rom #(
    parameter int POINTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [$clog2(POINTS)-1:0]         i_addr,
    output logic signed [ridft_pkg::COS_W-1:0] o_data
);
    import ridft_pkg::*;

    localparam longint PTS_L    = longint'(POINTS);
    localparam longint HALF_PTS = longint'(POINTS / 2);

    // round(32767 * cos(2*pi*k/POINTS)), folded into the first quadrant and
    // evaluated by a truncating Taylor series of 13 terms in Q2.30. Term t is
    // the previous term times -x^2 divided by (2t-1)*(2t).
    function automatic logic signed [COS_W-1:0] f_cos_entry(input int k);
        longint m;
        longint a;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint c;
        bit     neg;
        m   = longint'(k);
        neg = 1'b0;
        if (2 * m > PTS_L) begin
            m = PTS_L - m;
        end
        a = 2 * m;
        if (2 * a > PTS_L) begin
            a   = PTS_L - a;
            neg = 1'b1;
        end
        x    = (PI_Q30 * a + HALF_PTS) / PTS_L;
        x2   = (x * x) / Q30_ONE;
        term = Q30_ONE;
        sum  = Q30_ONE;
        term = -((term * x2) / Q30_ONE) / 2;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 12;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 30;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 56;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 90;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 132;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 182;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 240;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 306;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 380;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 462;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE) / 552;
        sum  = sum + term;
        if (sum < 0) begin
            sum = 0;
        end
        c = (sum * 32767 + Q30_ONE / 2) / Q30_ONE;
        return COS_W'(neg ? -c : c);
    endfunction

    logic signed [COS_W-1:0] w_rom [POINTS];
    logic signed [COS_W-1:0] r_data;

    for (genvar k = 0; k < POINTS; k++) begin : g_rom
        localparam logic signed [COS_W-1:0] ENTRY = f_cos_entry(k);
        assign w_rom[k] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== sv/real_inverse_dft.sv =====
// Top level of the real inverse DFT: sample ring, sequencer, MAC and output scaling.
`timescale 1ns / 1ps

// The block takes one frame of POINTS real Q1.15 samples on i_in, one sample per
// item, in frame order. Once the last sample of the frame has been taken it emits
// POINTS items on o_out; item i carries the cosine sum for bin i divided by
// POINTS, rounded half up and saturated to Q1.15, with bin_index and a last flag
// on the final item of the frame.
// The samples sit in a ring of POINTS cells. While loading, each accepted item
// shifts the ring by one; while computing, the ring rotates once per cycle unless
// the output stalls, so that the head cell feeds a single shared MAC unit, one
// term a cycle. i_in.ready is low while a frame is being computed and high while
// one is being loaded.
// Results leave through an output register. When the receiver holds o_out.ready
// low with a result waiting, the whole compute pipeline freezes and resumes
// without loss; loading of the next frame may proceed meanwhile.
// A synchronous reset discards any partial frame and any results in flight.
module real_inverse_dft #(
    parameter int POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ridft_in_if.sink    i_in,
    ridft_out_if.source o_out
);
    import ridft_pkg::*;

    localparam int IW     = $clog2(POINTS);
    localparam int ACC_W  = PROD_W + IW;
    localparam int Y_W    = IW + 18;
    localparam int FULL_W = Y_W + 15;
    localparam int Q_W    = 18;
    localparam int QP_W   = Q_W + IW + 1;

    localparam logic [IW-1:0]   LAST_IDX = IW'(POINTS - 1);
    localparam logic [IW:0]     PTS      = (IW + 1)'(POINTS);
    // Reciprocal of POINTS scaled by 2^Y_W; the quotient it gives is low by at most one.
    localparam logic [Y_W-1:0]  RECIP    = Y_W'((longint'(1) << Y_W) / POINTS);
    // Half an output step for rounding, plus an offset that keeps the value positive.
    localparam logic [FULL_W-1:0] BIAS   = (FULL_W'(POINTS) << 30) + (FULL_W'(POINTS) << 14);
    localparam logic signed [Q_W:0] Q_OFF = (Q_W + 1)'(32768);
    localparam logic signed [Q_W:0] V_MAX = (Q_W + 1)'(32767);
    localparam logic signed [Q_W:0] V_MIN = -(Q_W + 1)'(32768);

    // Sequencer state.
    t_state        r_state, n_state;
    logic [IW-1:0] r_load_cnt, n_load_cnt;
    logic [IW-1:0] r_term, n_term;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_phase, n_phase;
    logic [IW:0]   w_phase_sum;
    logic [IW-1:0] w_phase_next;
    logic          w_adv;
    logic          w_issue;
    logic          w_in_acc;
    logic          w_in_ready;

    // Sample ring.
    logic signed [SAMPLE_W-1:0] w_ring [POINTS];
    logic signed [SAMPLE_W-1:0] w_tail;
    logic                       w_ring_en;

    // Multiply-accumulate pipeline.
    logic signed [COS_W-1:0]    w_cos;
    logic                       r_s1_v, r_s1_first, r_s1_last;
    logic [IW-1:0]              r_s1_idx;
    logic signed [SAMPLE_W-1:0] r_s1_samp;
    logic signed [PROD_W-1:0]   w_prod;
    logic                       r_s2_v, r_s2_first, r_s2_last;
    logic [IW-1:0]              r_s2_idx;
    logic signed [PROD_W-1:0]   r_s2_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    w_sum;

    // Scaling pipeline.
    logic                    r_f1_v;
    logic [IW-1:0]           r_f1_idx;
    logic signed [ACC_W-1:0] r_f1_sum;
    logic [FULL_W-1:0]       w_num;
    logic                    r_f2_v;
    logic [IW-1:0]           r_f2_idx;
    logic [Y_W-1:0]          r_f2_y;
    logic [2*Y_W-1:0]        w_qprod;
    logic                    r_f3_v;
    logic [IW-1:0]           r_f3_idx;
    logic [Y_W-1:0]          r_f3_y;
    logic [Q_W-1:0]          r_f3_q;
    logic                    r_f4_v;
    logic [IW-1:0]           r_f4_idx;
    logic [Y_W-1:0]          r_f4_y;
    logic [Q_W-1:0]          r_f4_q;
    logic [QP_W-1:0]         r_f4_qp;
    logic [Y_W:0]            w_rem;
    logic [Q_W-1:0]          w_qc;
    logic signed [Q_W:0]     w_val;
    logic signed [Q_W:0]     w_sat;

    // Output register.
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [BIN_W-1:0]          r_out_bin;
    logic                      r_out_last;

    // The pipeline moves only when the output register can take a new result.
    assign w_adv    = !r_out_valid || o_out.ready;
    assign w_in_acc = i_in.valid && w_in_ready;

    assign w_phase_sum  = {1'b0, r_phase} + {1'b0, r_idx};
    assign w_phase_next = (w_phase_sum >= PTS) ? IW'(w_phase_sum - PTS) : w_phase_sum[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
            r_term     <= '0;
            r_idx      <= '0;
            r_phase    <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_term     <= n_term;
            r_idx      <= n_idx;
            r_phase    <= n_phase;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_term     = r_term;
        n_idx      = r_idx;
        n_phase    = r_phase;
        w_in_ready = 1'b0;
        w_issue    = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    if (r_load_cnt == LAST_IDX) begin
                        n_load_cnt = '0;
                        n_state    = ST_COMPUTE;
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end
            end
            ST_COMPUTE: begin
                if (w_adv) begin
                    w_issue = 1'b1;
                    if (r_term == LAST_IDX) begin
                        n_term  = '0;
                        n_phase = '0;
                        if (r_idx == LAST_IDX) begin
                            n_idx   = '0;
                            n_state = ST_LOAD;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else begin
                        n_term  = r_term + 1'b1;
                        n_phase = w_phase_next;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign i_in.ready = w_in_ready;

    // Loading shifts new samples in at the tail; computing rotates the head round.
    assign w_tail    = (r_state == ST_LOAD) ? i_in.sample : w_ring[0];
    assign w_ring_en = w_in_acc || w_issue;

    for (genvar i = 0; i < POINTS; i++) begin : g_ring
        if (i == POINTS - 1) begin : g_tail
            ridft_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_ring_en),
                .i_d   (w_tail),
                .o_q   (w_ring[i])
            );
        end else begin : g_body
            ridft_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_ring_en),
                .i_d   (w_ring[i+1]),
                .o_q   (w_ring[i])
            );
        end
    end

    ridft_rom #(
        .POINTS (POINTS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_addr (r_phase),
        .o_data (w_cos)
    );

    assign w_prod  = r_s1_samp * w_cos;
    assign w_sum   = r_s2_first ? ACC_W'(r_s2_prod)
                                : r_acc + {{(ACC_W-PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod};
    assign w_num   = {{(FULL_W-ACC_W){r_f1_sum[ACC_W-1]}}, r_f1_sum} + BIAS;
    assign w_qprod = (2*Y_W)'(r_f2_y) * (2*Y_W)'(RECIP);
    assign w_rem   = {1'b0, r_f4_y} - r_f4_qp;
    assign w_qc    = r_f4_q + Q_W'(w_rem >= (Y_W + 1)'(PTS));
    assign w_val   = $signed({1'b0, w_qc}) - Q_OFF;

    always_comb begin
        if (w_val > V_MAX) begin
            w_sat = V_MAX;
        end else if (w_val < V_MIN) begin
            w_sat = V_MIN;
        end else begin
            w_sat = w_val;
        end
    end

    // Valid flags of the pipeline stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_f1_v      <= 1'b0;
            r_f2_v      <= 1'b0;
            r_f3_v      <= 1'b0;
            r_f4_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_v      <= w_issue;
            r_s2_v      <= r_s1_v;
            r_f1_v      <= r_s2_v && r_s2_last;
            r_f2_v      <= r_f1_v;
            r_f3_v      <= r_f2_v;
            r_f4_v      <= r_f3_v;
            r_out_valid <= r_f4_v;
        end
    end

    // Payload of the pipeline stages.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_first <= (r_term == '0);
            r_s1_last  <= (r_term == LAST_IDX);
            r_s1_idx   <= r_idx;
            r_s1_samp  <= w_ring[0];

            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_idx   <= r_s1_idx;
            r_s2_prod  <= w_prod;

            if (r_s2_v) begin
                r_acc <= w_sum;
            end
            r_f1_sum <= w_sum;
            r_f1_idx <= r_s2_idx;

            r_f2_y   <= w_num[FULL_W-1:15];
            r_f2_idx <= r_f1_idx;

            r_f3_y   <= r_f2_y;
            r_f3_q   <= w_qprod[Y_W +: Q_W];
            r_f3_idx <= r_f2_idx;

            r_f4_y   <= r_f3_y;
            r_f4_q   <= r_f3_q;
            r_f4_qp  <= QP_W'(r_f3_q) * QP_W'(PTS);
            r_f4_idx <= r_f3_idx;

            r_out_value <= w_sat[VALUE_W-1:0];
            r_out_bin   <= BIN_W'(r_f4_idx);
            r_out_last  <= (r_f4_idx == LAST_IDX);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_out_value;
    assign o_out.bin_index = r_out_bin;
    assign o_out.last      = r_out_last;

endmodule

// ===== sv/ridft_chk.sv =====
// Port-level checker for the real inverse DFT and its bind to the top level.
`timescale 1ns / 1ps

module ridft_chk #(
    parameter int POINTS = 64
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic signed [ridft_pkg::VALUE_W-1:0]  i_out_value,
    input logic [ridft_pkg::BIN_W-1:0]           i_out_bin_index,
    input logic                                  i_out_last
);
    import ridft_pkg::*;

    localparam int            IW       = $clog2(POINTS);
    localparam int            CW       = IW + 3;
    localparam logic [IW-1:0] LAST_IDX = IW'(POINTS - 1);

    logic [IW-1:0] r_load_cnt;
    logic [IW-1:0] r_exp_idx;
    logic [CW-1:0] r_credit;
    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_frame_done;

    assign w_in_acc     = i_in_valid && i_in_ready;
    assign w_out_acc    = i_out_valid && i_out_ready;
    assign w_frame_done = w_in_acc && (r_load_cnt == LAST_IDX);

    // Results still owed: a whole frame's worth per completed frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_exp_idx  <= '0;
            r_credit   <= '0;
        end else begin
            if (w_in_acc) begin
                r_load_cnt <= (r_load_cnt == LAST_IDX) ? '0 : r_load_cnt + 1'b1;
            end
            if (w_out_acc) begin
                r_exp_idx <= (r_exp_idx == LAST_IDX) ? '0 : r_exp_idx + 1'b1;
            end
            r_credit <= r_credit + (w_frame_done ? CW'(POINTS) : '0) - CW'(w_out_acc);
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_bin_index) && $stable(i_out_last))
        else $error("stalled result changed");

    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (i_out_bin_index == BIN_W'(r_exp_idx))
            && (i_out_last == (r_exp_idx == LAST_IDX)))
        else $error("result out of frame order");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_credit != '0)
        else $error("result without a completed frame");

endmodule

bind real_inverse_dft ridft_chk #(
    .POINTS (POINTS)
) u_ridft_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_value     (o_out.value),
    .i_out_bin_index (o_out.bin_index),
    .i_out_last      (o_out.last)
);

// ===== test/ridft_frame_checker.sv =====
`timescale 1ns / 1ps
// Frame checker for the real inverse DFT: predicts every output of a frame and compares.
module ridft_frame_checker
    import ridft_pkg::*;
#(
    parameter int POINTS = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ridft_in_if   i_in_mon,
    ridft_out_if  i_out_mon,
    output int    o_failures,
    output int    o_pending,
    output int    o_results_seen
);

    localparam longint ONE_Q30     = 64'sd1 << 30;
    localparam longint PI_IN_Q30   = 64'sd3373259426;
    localparam int     SERIES_LEN  = 13;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [BIN_W-1:0]          bin_index;
        logic                      last;
    } bin_result_t;

    logic signed [COS_W-1:0]    cos_table [POINTS];
    logic signed [SAMPLE_W-1:0] frame_samples [POINTS];
    bin_result_t                expected_bins [$];
    int                         samples_loaded = 0;
    int                         failures = 0;
    int                         pending_bins = 0;
    int                         bins_received = 0;

    assign o_failures     = failures;
    assign o_pending      = pending_bins;
    assign o_results_seen = bins_received;

    // 32767 * cos(pi * num / den) for angles in the first quadrant, Taylor series in Q2.30.
    function automatic longint first_quadrant_cos(longint num, longint den);
        longint angle;
        longint angle_sq;
        longint term;
        longint total;
        longint t;
        angle    = (PI_IN_Q30 * num + den / 2) / den;
        angle_sq = (angle * angle) / ONE_Q30;
        term     = ONE_Q30;
        total    = ONE_Q30;
        for (t = 1; t < SERIES_LEN; t++) begin
            term  = -((term * angle_sq) / ONE_Q30) / ((2 * t - 1) * (2 * t));
            total = total + term;
        end
        if (total < 0) begin
            total = 0;
        end
        return (total * 32767 + ONE_Q30 / 2) / ONE_Q30;
    endfunction

    initial begin : build_cos_table
        longint folded;
        longint half_turns;
        longint magnitude;
        logic   negate;
        for (int k = 0; k < POINTS; k++) begin
            folded = k;
            negate = 1'b0;
            if (2 * folded > POINTS) begin
                folded = POINTS - folded;
            end
            half_turns = 2 * folded;
            if (2 * half_turns > POINTS) begin
                half_turns = POINTS - half_turns;
                negate     = 1'b1;
            end
            magnitude    = first_quadrant_cos(half_turns, POINTS);
            cos_table[k] = COS_W'(negate ? -magnitude : magnitude);
        end
    end

    // Divide by POINTS*2^15 rounding halves upwards, then clamp to Q1.15.
    function automatic logic signed [VALUE_W-1:0] scale_to_q15(longint acc);
        longint divisor;
        longint biased;
        longint quotient;
        divisor = longint'(POINTS) * 32768;
        biased  = acc + divisor / 2;
        if (biased >= 0) begin
            quotient = biased / divisor;
        end else begin
            quotient = -((-biased + divisor - 1) / divisor);
        end
        if (quotient > 32767) begin
            quotient = 32767;
        end
        if (quotient < -32768) begin
            quotient = -32768;
        end
        return VALUE_W'(quotient);
    endfunction

    task automatic predict_time_domain_frame();
        longint      acc;
        int          phase;
        bin_result_t bin_out;
        for (int bin = 0; bin < POINTS; bin++) begin
            acc   = 0;
            phase = 0;
            for (int term = 0; term < POINTS; term++) begin
                acc   = acc + longint'(frame_samples[term]) * longint'(cos_table[phase]);
                phase = phase + bin;
                if (phase >= POINTS) begin
                    phase = phase - POINTS;
                end
            end
            bin_out.value     = scale_to_q15(acc);
            bin_out.bin_index = BIN_W'(bin);
            bin_out.last      = (bin == POINTS - 1);
            expected_bins.push_back(bin_out);
        end
    endtask

    always @(posedge i_clk) begin
        bin_result_t want;
        if (i_rst_n) begin
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                bins_received++;
                if (expected_bins.size() == 0) begin
                    $error("unexpected output: value %0d, bin_index %0d, last %0b",
                           i_out_mon.value, i_out_mon.bin_index, i_out_mon.last);
                    failures++;
                end else begin
                    want = expected_bins.pop_front();
                    if (i_out_mon.value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, i_out_mon.value);
                        failures++;
                    end
                    if (i_out_mon.bin_index !== want.bin_index) begin
                        $error("bin_index: expected %0d, got %0d",
                               want.bin_index, i_out_mon.bin_index);
                        failures++;
                    end
                    if (i_out_mon.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_out_mon.last);
                        failures++;
                    end
                end
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                frame_samples[samples_loaded] = i_in_mon.sample;
                samples_loaded++;
                if (samples_loaded == POINTS) begin
                    predict_time_domain_frame();
                    samples_loaded = 0;
                end
            end
        end
        pending_bins = expected_bins.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Top of the real inverse DFT testbench: clock, reset, sample stimulus, output back-pressure.
module tb;
    import ridft_pkg::*;

    // The block is built with its default frame length of 64 samples.
    localparam int POINTS       = 64;
    localparam int FRAMES       = 4;
    localparam int DIRECTED_LEN = 20;
    // Long hold-off of the receiver, in clock cycles, so that the output register
    // fills, the compute pipeline freezes and the input stays stalled.
    localparam int HOLD_CYCLES  = 1500;

    // Sample patterns for whole frames of random stimulus.
    typedef enum {
        FILL_FULL_RANGE,
        FILL_ALL_MAX,
        FILL_ALL_MIN,
        FILL_SMALL,
        FILL_ALTERNATING
    } fill_t;

    // Directed head of the first frame: both extremes, zero, plus and minus one,
    // the halves, alternating bit patterns and repeated extremes, which together
    // drive every bit of the sample both ways.
    localparam logic signed [SAMPLE_W-1:0] DIRECTED_SAMPLES [DIRECTED_LEN] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
        16'sh4000, 16'shC000, 16'sh5555, 16'shAAAA, 16'sh7FFF,
        16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh00FF, 16'shFF00,
        16'sh0F0F, 16'shF0F0, 16'sh8001, 16'sh7FFE, 16'sh0000
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int failures;
    int pending;
    int results_seen;

    ridft_in_if  in_ch ();
    ridft_out_if out_ch ();

    real_inverse_dft #(
        .POINTS(POINTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // The checker watches both channels beside the block and reports a running
    // count of failures and of outputs still awaited.
    ridft_frame_checker #(
        .POINTS(POINTS)
    ) frame_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_results_seen(results_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: ends a run that hangs. Its limit leaves ample room for four frames
    // of loading and multiply-accumulate work, plus sender gaps, receiver stalls and
    // the long hold-off.
    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    // Chooses one sample of a frame according to the pattern for that frame.
    function automatic logic signed [SAMPLE_W-1:0] make_sample(fill_t fill, int pos);
        case (fill)
            FILL_ALL_MAX:     return 16'sh7FFF;
            FILL_ALL_MIN:     return 16'sh8000;
            FILL_SMALL:       return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
            FILL_ALTERNATING: return pos[0] ? 16'sh8000 : 16'sh7FFF;
            default:          return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offers one item from a falling edge and returns at the falling edge after
    // it has been taken. Valid stays high into the next call, so back-to-back
    // items are offered without a gap.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        in_ch.valid  = 1'b1;
        in_ch.sample = s;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Drops valid for a while; the sample bus carries noise meanwhile, which
    // the block must ignore.
    task automatic pause_sender(input int cycles);
        in_ch.valid  = 1'b0;
        in_ch.sample = SAMPLE_W'($urandom);
        repeat (cycles) @(negedge i_clk);
    endtask

    // Sender: whole frames only, in bursts of random length separated by
    // random gaps. Before the last frame it waits until every output of the
    // earlier frames has come back.
    initial begin : sender
        int                         burst_left;
        fill_t                      fill;
        logic signed [SAMPLE_W-1:0] s;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n    = 1'b1;
        burst_left = $urandom_range(1, 40);
        for (int frame = 0; frame < FRAMES; frame++) begin
            case (frame)
                0:       fill = FILL_FULL_RANGE;
                1:       fill = $urandom_range(0, 1) ? FILL_ALL_MAX : FILL_ALL_MIN;
                2:       fill = $urandom_range(0, 1) ? FILL_SMALL : FILL_ALTERNATING;
                default: fill = FILL_FULL_RANGE;
            endcase
            if (frame == FRAMES - 1) begin
                in_ch.valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            for (int pos = 0; pos < POINTS; pos++) begin
                if (frame == 0 && pos < DIRECTED_LEN) begin
                    s = DIRECTED_SAMPLES[pos];
                end else begin
                    s = make_sample(fill, pos);
                end
                send_sample(s);
                burst_left--;
                if (burst_left == 0) begin
                    pause_sender($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 40);
                end
            end
        end
        in_ch.valid = 1'b0;

        // Drain, then leave room for a stray output.
        while (pending != 0) @(negedge i_clk);
        repeat (2 * POINTS + 20) @(negedge i_clk);
        if (failures == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Receiver: ready switches in turn between always ready, a periodic stall and
    // random stalls, so that stalls land on every phase of the output cadence. Once
    // the second frame's outputs have begun it holds ready low for a long stretch
    // while the sender is already offering the next frame.
    initial begin : receiver
        int   cycle;
        logic hold_done;
        out_ch.ready = 1'b0;
        cycle        = 0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle++;
            if (!hold_done && results_seen >= POINTS + 6) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            case ((cycle / 300) % 3)
                0:       out_ch.ready = 1'b1;
                1:       out_ch.ready = (cycle % 7) > 1;
                default: out_ch.ready = $urandom_range(0, 3) != 0;
            endcase
        end
    end

endmodule
